// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects clk and the active-low synchronous reset rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define RSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/rss_pkg.sv =====
// shared constants, command/status structs and result type for the
// running sample statistics block; no dependencies
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int MEAN_W   = 24;
  localparam int SD_W     = 24;
  localparam int SUM_W    = 32;
  localparam int SUM2_W   = 48;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int SPLIT_W  = SUM2_W / 2;
  localparam int Q_FRAC   = 16;
  localparam int M_FRAC   = 8;
  localparam int NUM_W    = PROD_W + Q_FRAC;
  localparam int DEN_W    = 32;
  localparam int QUO_W    = 64;
  localparam int ITER_W   = 7;

  localparam logic [ITER_W-1:0] VAR_ITERS  = ITER_W'(NUM_W);
  localparam logic [ITER_W-1:0] MEAN_ITERS = ITER_W'(SUM_W + M_FRAC);

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic load;
    logic sqx;
    logic upd;
    logic mul0;
    logic mul1;
    logic mul2;
    logic diff;
    logic var_go;
    logic var_cap;
    logic mean_go;
    logic mean_cap;
    logic root_go;
    logic out_load;
  } rss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic root_done;
  } rss_stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  sample_count;
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] max_value;
    logic [MEAN_W-1:0]   mean_q8;
    logic [SD_W-1:0]     stddev_q8;
    logic                dropped;
  } rss_result_t;

endpackage

// ===== hw/rtl/rss_in_if.sv =====
// sample channel: valid/ready handshake with one sample per beat
// depends on rss_pkg
interface rss_in_if import rss_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

// ===== hw/rtl/rss_out_if.sv =====
// result channel: valid/ready handshake with one statistics record per beat
// depends on rss_pkg
interface rss_out_if import rss_pkg::*;;
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  sample_count;
  logic [SAMPLE_W-1:0] min_value;
  logic [SAMPLE_W-1:0] max_value;
  logic [MEAN_W-1:0]   mean_q8;
  logic [SD_W-1:0]     stddev_q8;
  logic                dropped;

  modport source (output valid, output sample_count, output min_value, output max_value,
                  output mean_q8, output stddev_q8, output dropped, input ready);
  modport sink (input valid, input sample_count, input min_value, input max_value,
                input mean_q8, input stddev_q8, input dropped, output ready);
endinterface

// ===== hw/rtl/running_sample_statistics_top.sv =====
// channel  | dir | beat contents
// in_chan  | in  | sample_value
// out_chan | out | sample_count, min_value, max_value, mean_q8, stddev_q8, dropped
//
// one sample at a time, no new sample until the last one's result is loaded:
// the 80-step variance division, the 40-step mean division and the
// 32-step square root run bit-serially on one divider and one root unit
// synchronous active-low reset clears the running count, min, max and sums to zero
// a waiting result sits in the output register; the next sample is taken
// meanwhile and only its finished result stalls on out_chan.ready
// depends on rss_pkg, rss_in_if, rss_out_if, rss_ctrl, rss_dp, assert_macros.svh
`include "assert_macros.svh"

module running_sample_statistics_top import rss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  rss_in_if.sink   in_chan,
  rss_out_if.source out_chan
);

  rss_cmd_t    cmd;
  rss_stat_t   stat;
  rss_result_t result;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_value (in_chan.sample_value),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result)
  );

  assign out_chan.sample_count = result.sample_count;
  assign out_chan.min_value    = result.min_value;
  assign out_chan.max_value    = result.max_value;
  assign out_chan.mean_q8      = result.mean_q8;
  assign out_chan.stddev_q8    = result.stddev_q8;
  assign out_chan.dropped      = result.dropped;

  // one sample in flight
  `RSS_ASSERT_NXT(a_one_in_flight, in_chan.valid && in_chan.ready, !in_chan.ready)
  // mean lies between min and max
  `RSS_ASSERT_IMP(a_mean_bounds, out_chan.valid,
    (out_chan.mean_q8 >= {out_chan.min_value, 8'h00}) &&
    (out_chan.mean_q8 <= {out_chan.max_value, 8'h00}))
  // a dropped sample only with a full count
  `RSS_ASSERT_IMP(a_drop_full, out_chan.valid && out_chan.dropped,
    out_chan.sample_count == COUNT_W'(COUNT_FULL))

endmodule

// ===== hw/rtl/rss_div.sv =====
// restoring divider, one quotient bit per cycle, msb-first dividend shift
// depends on rss_pkg
module rss_div import rss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [ITER_W-1:0] iters,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/rss_sqrt.sv =====
// floored integer square root, one result bit per cycle
// depends on rss_pkg
module rss_sqrt import rss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] x,
  output logic              done,
  output logic [SD_W-1:0]   root
);

  logic [PROD_W-1:0] x_r;
  logic [PROD_W-1:0] res_r;
  logic [PROD_W-1:0] bit_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W-1:0] trial;
  logic              ge;

  assign trial = res_r + bit_r;
  assign ge    = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      res_r <= '0;
      bit_r <= PROD_W'(1) << (PROD_W - 2);
    end else if (busy_r) begin
      x_r   <= ge ? x_r - trial : x_r;
      res_r <= ge ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[SD_W-1:0];

endmodule

// ===== hw/rtl/rss_dp.sv =====
// datapath: accumulators, shared multiplier, divider and root units,
// result register; depends on rss_pkg, rss_div and rss_sqrt
module rss_dp import rss_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  rss_cmd_t            cmd,
  output rss_stat_t           stat,
  output rss_result_t         result
);

  logic [COUNT_BITS-1:0] count_r;
  logic [SAMPLE_W-1:0]   min_r;
  logic [SAMPLE_W-1:0]   max_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM2_W-1:0]     sum2_r;
  logic [SAMPLE_W-1:0]   x_r;
  logic                  drop_r;
  logic [PROD_W-1:0]     mul_r;
  logic [PROD_W-1:0]     acc_r;
  logic [MEAN_W-1:0]     mean_r;
  rss_result_t           result_r;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [ITER_W-1:0] div_iters;
  logic [QUO_W-1:0]  div_quo;
  logic              div_done;
  logic [SD_W-1:0]   root;
  logic              root_done;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd.sqx) begin
      mul_a = MUL_W'(x_r);
      mul_b = MUL_W'(x_r);
    end else if (cmd.mul0) begin
      mul_a = MUL_W'(count_r);
      mul_b = MUL_W'(sum2_r[SPLIT_W-1:0]);
    end else if (cmd.mul1) begin
      mul_a = MUL_W'(count_r);
      mul_b = MUL_W'(sum2_r[SUM2_W-1:SPLIT_W]);
    end else if (cmd.mul2) begin
      mul_a = sum_r;
      mul_b = sum_r;
    end else if (cmd.diff) begin
      mul_a = MUL_W'(count_r);
      mul_b = MUL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // sample and running statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      sum2_r  <= '0;
    end else if (cmd.upd && !drop_r) begin
      count_r <= count_r + COUNT_BITS'(1);
      sum_r   <= sum_r + SUM_W'(x_r);
      sum2_r  <= sum2_r + SUM2_W'(mul_r[2*SAMPLE_W-1:0]);
      if (count_r == '0) begin
        min_r <= x_r;
        max_r <= x_r;
      end else begin
        if (x_r < min_r) min_r <= x_r;
        if (x_r > max_r) max_r <= x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= SAMPLE_W'(sample_value[SAMPLE_BITS-1:0]);
      drop_r <= count_r == COUNT_FULL;
    end
  end

  // count*sum2 in two halves, then minus sum^2, then variance quotient
  always_ff @(posedge clk) begin
    priority if (cmd.mul1) begin
      acc_r <= mul_r;
    end else if (cmd.mul2) begin
      acc_r <= acc_r + (mul_r << SPLIT_W);
    end else if (cmd.diff) begin
      acc_r <= (acc_r >= mul_r) ? acc_r - mul_r : '0;
    end else if (cmd.var_cap) begin
      acc_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_cap) mean_r <= div_quo[MEAN_W-1:0];
  end

  always_comb begin
    if (cmd.mean_go) begin
      div_num   = {sum_r, {M_FRAC{1'b0}}, {(NUM_W - SUM_W - M_FRAC){1'b0}}};
      div_den   = DEN_W'(count_r);
      div_iters = MEAN_ITERS;
    end else begin
      div_num   = {acc_r, {Q_FRAC{1'b0}}};
      div_den   = mul_r[DEN_W-1:0];
      div_iters = VAR_ITERS;
    end
  end

  rss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.var_go | cmd.mean_go),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quo   (div_quo)
  );

  rss_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_go),
    .x     (acc_r),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_r.sample_count <= COUNT_W'(count_r);
      result_r.min_value    <= min_r;
      result_r.max_value    <= max_r;
      result_r.mean_q8      <= mean_r;
      result_r.stddev_q8    <= root;
      result_r.dropped      <= drop_r;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.root_done = root_done;
  assign result         = result_r;

endmodule

// ===== hw/rtl/rss_ctrl.sv =====
// controller: sequences one sample through the datapath, owns the
// handshakes and the result valid flag; depends on rss_pkg
module rss_ctrl import rss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rss_stat_t stat,
  output rss_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQX   = 14'b00000000000010,
    S_UPD   = 14'b00000000000100,
    S_MUL0  = 14'b00000000001000,
    S_MUL1  = 14'b00000000010000,
    S_MUL2  = 14'b00000000100000,
    S_DIFF  = 14'b00000001000000,
    S_VGO   = 14'b00000010000000,
    S_VWAIT = 14'b00000100000000,
    S_MGO   = 14'b00001000000000,
    S_MWAIT = 14'b00010000000000,
    S_RGO   = 14'b00100000000000,
    S_RWAIT = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } rss_state_t;

  rss_state_t state_r;
  rss_state_t state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sqx   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_VGO;
      end
      S_VGO: begin
        cmd.var_go = 1'b1;
        state_nxt  = S_VWAIT;
      end
      S_VWAIT: begin
        if (stat.div_done) begin
          cmd.var_cap = 1'b1;
          state_nxt   = S_MGO;
        end
      end
      S_MGO: begin
        cmd.mean_go = 1'b1;
        state_nxt   = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.mean_cap = 1'b1;
          state_nxt    = S_RGO;
        end
      end
      S_RGO: begin
        cmd.root_go = 1'b1;
        state_nxt   = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.root_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== test/running_sample_statistics_top_test.sv =====
// self-checking testbench for running_sample_statistics_top: random and directed samples,
// results checked against an in-bench fixed-point model of count, min, max, mean, stddev
// depends on rss_pkg, rss_in_if, rss_out_if and the running_sample_statistics_top rtl
module running_sample_statistics_top_test;
  import rss_pkg::*;

  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;
  localparam int HOLD_AT     = 40;
  localparam int DRAIN_CYCLES = 250;
  localparam int CALM_TAIL   = 60;

  logic clk;
  logic rst_n;

  rss_in_if  sample_chan ();
  rss_out_if stats_chan ();

  running_sample_statistics_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (sample_chan),
    .out_chan(stats_chan)
  );

  logic [SAMPLE_W-1:0] samples_pending[$];
  rss_result_t         stats_due[$];
  int                  total_samples;
  int                  samples_sent;
  int                  results_seen;
  int                  error_count;

  logic [COUNT_BITS-1:0] stat_count;
  logic [SAMPLE_W-1:0]   stat_min;
  logic [SAMPLE_W-1:0]   stat_max;
  logic [SUM_W-1:0]      stat_sum;
  logic [SUM2_W-1:0]     stat_sum_sq;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want, int idx);
    if (got != want) begin
      report_error($sformatf("result %0d %s got 0x%0h want 0x%0h", idx, name, got, want));
    end
  endtask

  function automatic logic [31:0] floor_sqrt64(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] place;
    root  = '0;
    place = 64'h1 << 62;
    while (place > v) place = place >> 2;
    while (place != 0) begin
      if (v >= root + place) begin
        v    = v - (root + place);
        root = (root >> 1) + place;
      end else begin
        root = root >> 1;
      end
      place = place >> 2;
    end
    return root[31:0];
  endfunction

  // adds one sample to the running statistics and returns the record it should produce
  function automatic rss_result_t fold_sample(logic [SAMPLE_W-1:0] x);
    rss_result_t r;
    logic [63:0] prod;
    logic [63:0] sq;
    logic [63:0] diff;
    logic [63:0] den;
    logic [79:0] var_q16;
    logic [39:0] mean_full;
    logic [31:0] root;
    r = '0;
    if (stat_count == COUNT_FULL) begin
      r.dropped = 1'b1;
    end else begin
      if (stat_count == '0) begin
        stat_min = x;
        stat_max = x;
      end else begin
        if (x < stat_min) stat_min = x;
        if (x > stat_max) stat_max = x;
      end
      stat_sum    = stat_sum + SUM_W'(x);
      stat_sum_sq = stat_sum_sq + SUM2_W'(32'(x) * 32'(x));
      stat_count  = stat_count + COUNT_BITS'(1);
    end
    prod      = 64'(stat_count) * 64'(stat_sum_sq);
    sq        = 64'(stat_sum) * 64'(stat_sum);
    diff      = (prod >= sq) ? prod - sq : 64'h0;
    den       = 64'(stat_count) * 64'(stat_count);
    var_q16   = {diff, 16'h0} / 80'(den);
    mean_full = {stat_sum, 8'h0} / 40'(stat_count);
    root      = floor_sqrt64(var_q16[63:0]);
    r.sample_count = COUNT_W'(stat_count);
    r.min_value    = stat_min;
    r.max_value    = stat_max;
    r.mean_q8      = mean_full[MEAN_W-1:0];
    r.stddev_q8    = root[SD_W-1:0];
    return r;
  endfunction

  // idle odds in percent, changing every 50 beats so that calm stretches occur
  function automatic int burst_odds(int idx);
    case ((idx / 50) % 4)
      0: return 0;
      1: return 25;
      2: return 60;
      default: return 10;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(int kind, logic [SAMPLE_W-1:0] base);
    case (kind)
      0: return SAMPLE_W'($urandom_range(0, 65535));
      1: return SAMPLE_W'($urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3: return base;
      4: return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      default: return ~(SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1));
    endcase
  endfunction

  // sample driver
  int src_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      sample_chan.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (sample_chan.valid && sample_chan.ready) begin
        stats_due = {stats_due, fold_sample(sample_chan.sample_value)};
        samples_sent++;
      end
      if (!sample_chan.valid || sample_chan.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          sample_chan.valid <= 1'b0;
        end else if (samples_pending.size() == 0) begin
          sample_chan.valid <= 1'b0;
        end else if (samples_pending.size() > CALM_TAIL &&
                     $urandom_range(0, 99) < burst_odds(samples_sent)) begin
          src_gap = $urandom_range(0, 3);
          sample_chan.valid <= 1'b0;
        end else begin
          sample_chan.valid        <= 1'b1;
          sample_chan.sample_value <= samples_pending.pop_front();
        end
      end
    end
  end

  // result monitor and receiver
  int sink_gap;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    rss_result_t want;
    if (!rst_n) begin
      stats_chan.ready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (stats_chan.valid && stats_chan.ready) begin
        if (stats_due.size() == 0) begin
          report_error($sformatf("result %0d arrived with no sample outstanding", results_seen));
        end else begin
          want = stats_due.pop_front();
          check_field("sample_count", stats_chan.sample_count, want.sample_count, results_seen);
          check_field("min_value", stats_chan.min_value, want.min_value, results_seen);
          check_field("max_value", stats_chan.max_value, want.max_value, results_seen);
          check_field("mean_q8", stats_chan.mean_q8, want.mean_q8, results_seen);
          check_field("stddev_q8", stats_chan.stddev_q8, want.stddev_q8, results_seen);
          check_field("dropped", stats_chan.dropped, want.dropped, results_seen);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stats_chan.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stats_chan.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        stats_chan.ready <= 1'b0;
      end else if (results_seen < total_samples - CALM_TAIL &&
                   $urandom_range(0, 99) < burst_odds(results_seen + 25)) begin
        sink_gap = $urandom_range(0, 3);
        stats_chan.ready <= 1'b0;
      end else begin
        stats_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_chan.valid && sample_chan.ready) || (stats_chan.valid && stats_chan.ready) ||
          !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [SAMPLE_W-1:0] directed[] = {16'd40000, 16'd40000, 16'hFFFF, 16'h0000, 16'h0000,
                                       16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                                       16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h0000,
                                       16'hFFFF, 16'd12345, 16'h00FF, 16'hFF00, 16'h0001};
    logic [SAMPLE_W-1:0] base;
    int kind;
    int run;
    rst_n                    = 1'b0;
    sample_chan.valid        = 1'b0;
    sample_chan.sample_value = '0;
    stats_chan.ready         = 1'b0;
    stat_count   = '0;
    stat_min     = '0;
    stat_max     = '0;
    stat_sum     = '0;
    stat_sum_sq  = '0;
    samples_sent = 0;
    results_seen = 0;
    error_count  = 0;

    foreach (directed[i]) samples_pending = {samples_pending, directed[i]};
    while (samples_pending.size() < 500) begin
      kind = $urandom_range(0, 5);
      base = SAMPLE_W'($urandom_range(0, 65535));
      run  = $urandom_range(1, 20);
      repeat (run) samples_pending = {samples_pending, random_sample(kind, base)};
    end
    total_samples = samples_pending.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_pending.size() != 0 || sample_chan.valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (stats_due.size() != 0) begin
      report_error($sformatf("%0d results never arrived", stats_due.size()));
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rss_pkg.sv
hw/rtl/rss_in_if.sv
hw/rtl/rss_out_if.sv
hw/rtl/rss_div.sv
hw/rtl/rss_sqrt.sv
hw/rtl/rss_dp.sv
hw/rtl/rss_ctrl.sv
hw/rtl/running_sample_statistics_top.sv
test/running_sample_statistics_top_test.sv
